// ----- hw/rtl/ppkd_pkg.sv -----
`default_nettype none

package ppkd_pkg;

    localparam int PIN_W        = 4;
    localparam int KEY_W        = 8;
    localparam int CNT_W        = 4;
    localparam int KIND_W       = 2;
    localparam int NUM_PINS_DEF = 13;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(3);

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic             pressed;
        logic [CNT_W-1:0] count;
    } t_key_state;

endpackage

`default_nettype wire

// ----- hw/rtl/ppkd_ifs.sv -----
`default_nettype none

interface ppkd_sample_if;
    logic valid;
    logic ready;
    logic sense_level;

    modport source (output valid, output sense_level, input ready);
    modport sink (input valid, input sense_level, output ready);
endinterface

interface ppkd_event_if;
    logic                       valid;
    logic                       ready;
    logic [ppkd_pkg::KIND_W-1:0] event_kind;
    logic [ppkd_pkg::KEY_W-1:0]  key_number;
    logic [ppkd_pkg::PIN_W-1:0]  next_drive_pin;
    logic [ppkd_pkg::PIN_W-1:0]  next_sense_pin;

    modport source (output valid, output event_kind, output key_number,
                    output next_drive_pin, output next_sense_pin, input ready);
    modport sink (input valid, input event_kind, input key_number,
                  input next_drive_pin, input next_sense_pin, output ready);
endinterface

interface ppkd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ppkd_pkg::CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppkd_cell.sv -----
`default_nettype none

module ppkd_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_shift,
    input  wire ppkd_pkg::t_key_state i_state,
    output ppkd_pkg::t_key_state      o_state
);

    ppkd_pkg::t_key_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_shift) begin
            r_state <= i_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- hw/rtl/ppkd_update.sv -----
`default_nettype none

module ppkd_update (
    input  wire                         i_level,
    input  wire [ppkd_pkg::CNT_W-1:0]   i_threshold,
    input  wire ppkd_pkg::t_key_state   i_state,
    output ppkd_pkg::t_key_state        o_state,
    output ppkd_pkg::t_event_kind       o_kind
);

    logic [ppkd_pkg::CNT_W-1:0] cnt_inc;

    assign cnt_inc = (i_state.count == ppkd_pkg::CNT_MAX) ? i_state.count
                                                          : i_state.count + 1'b1;

    always_comb begin
        o_state = i_state;
        o_kind  = ppkd_pkg::EV_NONE;
        if (i_level) begin
            o_state.count = cnt_inc;
            if (cnt_inc >= i_threshold && !i_state.pressed) begin
                o_state.pressed = 1'b1;
                o_kind          = ppkd_pkg::EV_PRESS;
            end
        end else begin
            o_state.count = '0;
            if (i_state.pressed) begin
                o_state.pressed = 1'b0;
                o_kind          = ppkd_pkg::EV_RELEASE;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pin_pair_key_scan_debounce_core.sv -----
`default_nettype none

// channel   | dir | modport | payload
// i_sample  | in  | sink    | sense_level
// o_event   | out | source  | event_kind, key_number, next_drive_pin, next_sense_pin
// i_cfg     | in  | sink    | data (debounce threshold), always ready
//
// one word per cycle unless o_event stalls; the result is registered in the cycle after the sample is taken
// key state lives in a ring of NUM_PINS*(NUM_PINS-1) cells rotated once per sample,
// so the head cell is always the key being scanned
// synchronous reset clears every cell at once, no clearing pass
// a stalled output register holds; a new sample is taken when it is empty or draining

module pin_pair_key_scan_debounce_core #(
    parameter int NUM_PINS = ppkd_pkg::NUM_PINS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ppkd_sample_if.sink  i_sample,
    ppkd_event_if.source o_event,
    ppkd_cfg_if.sink     i_cfg
);

    localparam int NUM_KEYS = NUM_PINS * (NUM_PINS - 1);
    localparam logic [ppkd_pkg::PIN_W:0] PINS_V = (ppkd_pkg::PIN_W + 1)'(NUM_PINS);

    logic [ppkd_pkg::CNT_W-1:0] r_threshold;
    logic [ppkd_pkg::PIN_W-1:0] r_drive, n_drive;
    logic [ppkd_pkg::PIN_W-1:0] r_sense, n_sense;
    logic [ppkd_pkg::KEY_W-1:0] r_key, n_key;

    logic                        r_out_valid;
    logic [ppkd_pkg::KIND_W-1:0] r_kind;
    logic [ppkd_pkg::KEY_W-1:0]  r_key_out;
    logic [ppkd_pkg::PIN_W-1:0]  r_nd;
    logic [ppkd_pkg::PIN_W-1:0]  r_ns;

    logic                  acc;
    ppkd_pkg::t_key_state  ring [NUM_KEYS];
    ppkd_pkg::t_key_state  head_next;
    ppkd_pkg::t_event_kind kind;

    assign i_sample.ready = !r_out_valid || o_event.ready;
    assign acc            = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ppkd_pkg::THR_RESET;
        end else if (i_cfg.valid) begin
            r_threshold <= i_cfg.data;
        end
    end

    // ring of key cells, head at index 0
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
        if (g == NUM_KEYS - 1) begin : g_tail
            ppkd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (acc),
                .i_state (head_next),
                .o_state (ring[g])
            );
        end else begin : g_mid
            ppkd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (acc),
                .i_state (ring[g+1]),
                .o_state (ring[g])
            );
        end
    end

    ppkd_update u_update (
        .i_level     (i_sample.sense_level),
        .i_threshold (r_threshold),
        .i_state     (ring[0]),
        .o_state     (head_next),
        .o_kind      (kind)
    );

    // scan position advance
    always_comb begin
        logic [ppkd_pkg::PIN_W:0] d;
        logic [ppkd_pkg::PIN_W:0] s;
        d = {1'b0, r_drive};
        s = {1'b0, r_sense} + 1'b1;
        if (s == d) begin
            s = s + 1'b1;
        end
        n_key = r_key + 1'b1;
        if (s >= PINS_V) begin
            d = d + 1'b1;
            s = '0;
            if (d >= PINS_V) begin
                d     = '0;
                s     = (ppkd_pkg::PIN_W + 1)'(1);
                n_key = ppkd_pkg::KEY_W'(1);
            end
        end
        n_drive = d[ppkd_pkg::PIN_W-1:0];
        n_sense = s[ppkd_pkg::PIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive     <= '0;
            r_sense     <= ppkd_pkg::PIN_W'(1);
            r_key       <= ppkd_pkg::KEY_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_drive <= n_drive;
                r_sense <= n_sense;
                r_key   <= n_key;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_kind    <= kind;
            r_key_out <= r_key;
            r_nd      <= n_drive;
            r_ns      <= n_sense;
        end
    end

    assign o_event.valid          = r_out_valid;
    assign o_event.event_kind     = r_kind;
    assign o_event.key_number     = r_key_out;
    assign o_event.next_drive_pin = r_nd;
    assign o_event.next_sense_pin = r_ns;

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key >= ppkd_pkg::KEY_W'(1) && r_key <= ppkd_pkg::KEY_W'(NUM_KEYS))
        else $error("scan key out of range");

    a_pins_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive != r_sense)
        else $error("drive and sense pins equal");

    a_key_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_key_out == $past(r_key))
        else $error("result key does not match sampled slot");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(acc))
        else $error("result word without a sample");

endmodule

`default_nettype wire

// ----- bench/ppkd_scan_checker.sv -----
`timescale 1ns / 100ps

module ppkd_scan_checker #(
    parameter int NUM_PINS = ppkd_pkg::NUM_PINS_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    ppkd_sample_if i_sample,
    ppkd_event_if  i_event,
    ppkd_cfg_if    i_cfg,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int NUM_KEYS = NUM_PINS * (NUM_PINS - 1);

    typedef struct packed {
        ppkd_pkg::t_event_kind      kind;
        logic [ppkd_pkg::KEY_W-1:0] key_num;
        logic [ppkd_pkg::PIN_W-1:0] drive_pin;
        logic [ppkd_pkg::PIN_W-1:0] sense_pin;
    } t_scan_word;

    logic                       key_down [NUM_KEYS];
    logic [ppkd_pkg::CNT_W-1:0] key_hits [NUM_KEYS];
    int                         drive_at;
    int                         sense_at;
    int                         key_at;
    logic [ppkd_pkg::CNT_W-1:0] press_threshold;
    t_scan_word                 scan_words_due[$];
    int                         mismatch_cnt = 0;

    function automatic void note_mismatch(string msg);
        if (mismatch_cnt < 10) begin
            $display("[%0t] scan checker: %s", $time, msg);
        end
        mismatch_cnt++;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            note_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
        end
    endfunction

    // debounce one sample of the key under scan, then step to the next pin pair
    function automatic t_scan_word predict_scan_word(input logic level);
        t_scan_word w;
        int         k;
        int         d;
        int         s;
        w.kind    = ppkd_pkg::EV_NONE;
        w.key_num = ppkd_pkg::KEY_W'(key_at);
        k = key_at - 1;
        if (level) begin
            if (key_hits[k] != ppkd_pkg::CNT_MAX) begin
                key_hits[k] = key_hits[k] + 1'b1;
            end
            if (key_hits[k] >= press_threshold && !key_down[k]) begin
                key_down[k] = 1'b1;
                w.kind      = ppkd_pkg::EV_PRESS;
            end
        end else begin
            key_hits[k] = '0;
            if (key_down[k]) begin
                key_down[k] = 1'b0;
                w.kind      = ppkd_pkg::EV_RELEASE;
            end
        end
        d = drive_at;
        s = sense_at + 1;
        if (s == d) begin
            s++;
        end
        if (s >= NUM_PINS) begin
            d++;
            s = 0;
        end
        if (d >= NUM_PINS) begin
            drive_at = 0;
            sense_at = 1;
            key_at   = 1;
        end else begin
            drive_at = d;
            sense_at = s;
            key_at   = (key_at == NUM_KEYS) ? 1 : key_at + 1;
        end
        w.drive_pin = ppkd_pkg::PIN_W'(drive_at);
        w.sense_pin = ppkd_pkg::PIN_W'(sense_at);
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_scan_word got;
        t_scan_word want;
        t_scan_word due;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                key_down[i] = 1'b0;
                key_hits[i] = '0;
            end
            drive_at        = 0;
            sense_at        = 1;
            key_at          = 1;
            press_threshold = ppkd_pkg::THR_RESET;
            scan_words_due.delete();
        end else begin
            if (i_event.valid && i_event.ready) begin
                got.kind      = ppkd_pkg::t_event_kind'(i_event.event_kind);
                got.key_num   = i_event.key_number;
                got.drive_pin = i_event.next_drive_pin;
                got.sense_pin = i_event.next_sense_pin;
                if (scan_words_due.size() == 0) begin
                    note_mismatch($sformatf("event word with nothing expected: %h", got));
                end else begin
                    want = scan_words_due.pop_front();
                    check_field("event_kind", want.kind, got.kind);
                    check_field("key_number", want.key_num, got.key_num);
                    check_field("next_drive_pin", want.drive_pin, got.drive_pin);
                    check_field("next_sense_pin", want.sense_pin, got.sense_pin);
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                due = predict_scan_word(i_sample.sense_level);
                scan_words_due.insert(scan_words_due.size(), due);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                press_threshold = i_cfg.data;
            end
        end
        o_pending    <= scan_words_due.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

// ----- bench/tb_pin_pair_key_scan_debounce_core.sv -----
`timescale 1ns / 100ps

module tb_pin_pair_key_scan_debounce_core;

    localparam int NUM_PINS    = ppkd_pkg::NUM_PINS_DEF;
    localparam int NUM_KEYS    = NUM_PINS * (NUM_PINS - 1);
    localparam int CYCLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;

    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   hold_asked   = 0;
    int   hold_done    = 0;
    int   rx_hold_cnt  = 0;
    int   scan_pos     = 0;
    logic key_held [NUM_KEYS];

    ppkd_sample_if smp_if();
    ppkd_event_if  evt_if();
    ppkd_cfg_if    cfg_if();

    pin_pair_key_scan_debounce_core #(
        .NUM_PINS(NUM_PINS)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sample(smp_if),
        .o_event (evt_if),
        .i_cfg   (cfg_if)
    );

    ppkd_scan_checker #(
        .NUM_PINS(NUM_PINS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample    (smp_if),
        .i_event     (evt_if),
        .i_cfg       (cfg_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_pin_pair_key_scan_debounce_core: done, errors");
            $finish;
        end
    end

    // event receiver, with a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            evt_if.ready <= 1'b0;
            rx_hold_cnt  <= 0;
        end else if (hold_done != hold_asked) begin
            hold_done    <= hold_asked;
            rx_hold_cnt  <= HOLD_CYCLES;
            evt_if.ready <= 1'b0;
        end else if (rx_hold_cnt > 0) begin
            rx_hold_cnt  <= rx_hold_cnt - 1;
            evt_if.ready <= 1'b0;
        end else begin
            evt_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_level(input logic level);
        while ($urandom_range(99) < snd_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge clk);
        end
        smp_if.valid       <= 1'b1;
        smp_if.sense_level <= level;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        scan_pos = (scan_pos + 1) % NUM_KEYS;
    endtask

    task automatic wait_until_drained();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [ppkd_pkg::CNT_W-1:0] thr);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= thr;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // keys mostly keep their held state across scans, with occasional glitches
    task automatic send_key_activity(input int count, input int flip_pct, input int noise_pct,
                                     input int hold_at, input int drain_at);
        logic level;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_asked <= hold_asked + 1;
            end
            if (n == drain_at) begin
                wait_until_drained();
            end
            if ($urandom_range(99) < flip_pct) begin
                key_held[scan_pos] = ~key_held[scan_pos];
            end
            level = key_held[scan_pos] ^ ($urandom_range(99) < noise_pct);
            send_level(level);
        end
    endtask

    initial begin
        smp_if.valid       = 1'b0;
        smp_if.sense_level = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        rst_n              = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_held[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold: single high samples must not press
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b1);
        send_level(1'b0);
        wait_until_drained();

        // zero threshold: first high sample presses
        write_threshold(ppkd_pkg::CNT_W'(0));
        for (int i = 0; i < 12; i++) begin
            send_level(i[0] | i[2]);
        end
        wait_until_drained();

        write_threshold(ppkd_pkg::CNT_W'(1));
        snd_idle_pct = 27;
        rcv_idle_pct <= 65;
        send_key_activity(228, 25, 5, 150, -1);
        wait_until_drained();

        // keys held over more than one scan
        write_threshold(ppkd_pkg::CNT_W'(2));
        snd_idle_pct = 65;
        rcv_idle_pct <= 27;
        send_key_activity(228, 10, 3, -1, -1);
        wait_until_drained();

        write_threshold(ppkd_pkg::CNT_W'(3));
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        send_key_activity(228, 15, 5, -1, 200);
        wait_until_drained();

        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_pin_pair_key_scan_debounce_core: done, clean");
        end else begin
            $display("tb_pin_pair_key_scan_debounce_core: done, errors");
        end
        $finish;
    end

endmodule
